// ===== sv/rdf_pkg.sv =====
// Shared types and constants of the read duplicate filter.
`default_nettype none
package rdf_pkg;

    localparam int REQ_W      = 2;
    localparam int CHROM_W    = 2;
    localparam int POS_W      = 12;
    localparam int RAND_W     = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = 3;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;
    localparam int STEP_W     = $clog2(RAND_W);

    localparam logic [CFG_W-1:0]  CHROM_COUNT_RST = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST       = STEP_W'(RAND_W - 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_COUNT   = 2'd0,
        REQ_RESOLVE = 2'd1,
        REQ_FILTER  = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

endpackage
`default_nettype wire

// ===== sv/rdf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module rdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/read_duplicate_filter.sv =====
// Top level of the read duplicate filter with its two count tables and control.
//
// The block keeps a pair-end and a single-end count table in two RAMs addressed by
// chromosome times POSITIONS plus the key position. After reset a clearing pass
// writes zero to all CHROMS*POSITIONS entries (16384 with the default parameters), one
// per cycle, and no item is taken until it ends. Count and filter items are read in
// S_IDLE, then modified, written back and loaded into the result register in S_READ
// once it is free; out-of-range and unused items only load it. A resolve item that
// must draw a new representative passes S_DIV, where a shift-subtract unit forms the
// remainder of the 16-bit random draw one bit per cycle, and S_FIN to write back.
// The result register lets the next item in while a result waits to be taken.
`default_nettype none
module read_duplicate_filter #(
    parameter int CHROMS     = 4,
    parameter int POSITIONS  = 4096,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [rdf_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // chrom_index, start_first, start_second, rand_value, zero pad
    input  wire logic [rdf_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type, is_pair
    input  wire logic [rdf_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // count_after
    output logic      [rdf_pkg::OUT_DATA_W-1:0]  m_tdata,
    // keep, error
    output logic      [rdf_pkg::OUT_USER_W-1:0]  m_tuser
);

    import rdf_pkg::*;

    localparam int DEPTH = CHROMS * POSITIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = COUNT_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CB-1:0] COUNT_MAX = '1;

    t_state r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [CFG_W-1:0]   r_chrom_count;
    logic [AW-1:0]      r_addr, n_addr;
    logic [REQ_W-1:0]   r_req, n_req;
    logic               r_pair, n_pair;
    logic               r_skip, n_skip;
    logic               r_err, n_err;
    logic [RAND_W-1:0]  r_rand, n_rand;
    logic [CB-1:0]      r_div, n_div;
    logic [CB-1:0]      r_rem, n_rem;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_res_pair, n_res_pair;
    logic               r_out_valid;
    logic               r_out_keep, r_out_err;
    logic [OUT_W-1:0]   r_out_cnt;

    logic [REQ_W-1:0]   in_req;
    logic               in_pair;
    logic [CHROM_W-1:0] in_chrom;
    logic [POS_W-1:0]   in_s1, in_s2, in_pos;
    logic [RAND_W-1:0]  in_rand;
    logic               in_err;
    logic [AW-1:0]      in_addr;

    logic [AW-1:0]      rd_addr, wr_addr;
    logic [CB-1:0]      pc, sc, cur_cnt;
    logic               wr_pair_en, wr_single_en;
    logic [CB-1:0]      wr_pair_data, wr_single_data;
    logic               slot_free;
    logic               load_out, out_keep, out_err;
    logic [CB-1:0]      out_cnt;
    logic [CB:0]        trial;
    logic               trial_ge;
    logic [CB-1:0]      draw;

    assign in_req   = s_tuser[1:0];
    assign in_pair  = s_tuser[2];
    assign in_chrom = s_tdata[1:0];
    assign in_s1    = s_tdata[13:2];
    assign in_s2    = s_tdata[25:14];
    assign in_rand  = s_tdata[41:26];

    assign in_pos = (in_req != REQ_RESOLVE && in_pair && in_s2 < in_s1) ? in_s2 : in_s1;
    assign in_err = ({1'b0, in_chrom} >= r_chrom_count) ||
                    (32'(in_chrom) >= 32'(CHROMS)) ||
                    (32'(in_pos) >= 32'(POSITIONS));
    assign in_addr = AW'(32'(in_chrom) * 32'(POSITIONS) + 32'(in_pos));

    assign s_tready  = (r_state == S_IDLE);
    assign rd_addr   = (r_state == S_IDLE) ? in_addr : r_addr;
    assign wr_addr   = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign slot_free = !r_out_valid || m_tready;
    assign cur_cnt   = r_pair ? pc : sc;
    assign trial     = {r_rem, r_rand[RAND_W-1]};
    assign trial_ge  = trial >= {1'b0, r_div};
    assign draw      = r_rem + CB'(1);

    rdf_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_pair_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_pair_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_pair_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (pc)
    );

    rdf_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_single_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_single_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_single_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (sc)
    );

    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_addr         = r_addr;
        n_req          = r_req;
        n_pair         = r_pair;
        n_skip         = r_skip;
        n_err          = r_err;
        n_rand         = r_rand;
        n_div          = r_div;
        n_rem          = r_rem;
        n_step         = r_step;
        n_res_pair     = r_res_pair;
        wr_pair_en     = 1'b0;
        wr_single_en   = 1'b0;
        wr_pair_data   = '0;
        wr_single_data = '0;
        load_out       = 1'b0;
        out_keep       = 1'b0;
        out_err        = 1'b0;
        out_cnt        = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_pair_en   = 1'b1;
                wr_single_en = 1'b1;
                n_clr_addr   = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    n_addr  = in_addr;
                    n_req   = in_req;
                    n_pair  = in_pair;
                    n_err   = in_err && (in_req != REQ_UNUSED);
                    n_skip  = in_err || (in_req == REQ_UNUSED);
                    n_rand  = in_rand;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_skip) begin
                    if (slot_free) begin
                        load_out = 1'b1;
                        out_err  = r_err;
                        n_state  = S_IDLE;
                    end
                end else begin
                    unique case (r_req)
                        REQ_COUNT: begin
                            out_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + CB'(1);
                            if (slot_free) begin
                                wr_pair_en     = r_pair;
                                wr_single_en   = !r_pair;
                                wr_pair_data   = out_cnt;
                                wr_single_data = out_cnt;
                                load_out       = 1'b1;
                                n_state        = S_IDLE;
                            end
                        end
                        REQ_FILTER: begin
                            out_cnt  = (cur_cnt == '0) ? cur_cnt : cur_cnt - CB'(1);
                            out_keep = (cur_cnt == CB'(1));
                            if (slot_free) begin
                                wr_pair_en     = r_pair;
                                wr_single_en   = !r_pair;
                                wr_pair_data   = out_cnt;
                                wr_single_data = out_cnt;
                                load_out       = 1'b1;
                                n_state        = S_IDLE;
                            end
                        end
                        REQ_RESOLVE: begin
                            n_rem  = '0;
                            n_step = '0;
                            if (pc != '0) begin
                                if (pc > CB'(1)) begin
                                    n_div      = pc;
                                    n_res_pair = 1'b1;
                                    n_state    = S_DIV;
                                end else if (slot_free) begin
                                    wr_single_en = 1'b1;
                                    out_cnt      = pc;
                                    load_out     = 1'b1;
                                    n_state      = S_IDLE;
                                end
                            end else if (sc > CB'(1)) begin
                                n_div      = sc;
                                n_res_pair = 1'b0;
                                n_state    = S_DIV;
                            end else if (slot_free) begin
                                out_cnt  = sc;
                                load_out = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        default: begin
                            if (slot_free) begin
                                load_out = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem  = trial_ge ? CB'(trial - {1'b0, r_div}) : CB'(trial);
                n_rand = {r_rand[RAND_W-2:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                out_cnt = draw;
                if (slot_free) begin
                    wr_pair_en     = r_res_pair;
                    wr_pair_data   = draw;
                    wr_single_en   = 1'b1;
                    wr_single_data = r_res_pair ? '0 : draw;
                    load_out       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_chrom_count <= CHROM_COUNT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_wr_en) begin
                r_chrom_count <= i_cfg_wr_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_req      <= n_req;
        r_pair     <= n_pair;
        r_skip     <= n_skip;
        r_err      <= n_err;
        r_rand     <= n_rand;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_res_pair <= n_res_pair;
        if (load_out) begin
            r_out_keep <= out_keep;
            r_out_err  <= out_err;
            r_out_cnt  <= OUT_W'(out_cnt);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_cnt;
    assign m_tuser  = {r_out_err, r_out_keep};

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_tready)
        else $error("input transfer offered during the clearing pass");

    a_accept_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == S_READ))
        else $error("accepted transfer did not start a table read");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div) && (r_div > CB'(1)))
        else $error("remainder unit left its range");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0) && !m_tuser[0])
        else $error("error result carries a count or keep flag");

    a_keep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("kept read reports a nonzero count");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_read_duplicate_filter.sv =====
// Self-checking testbench for the read duplicate filter, with a table-based predictor.
`timescale 1ns / 1ps
module tb_read_duplicate_filter;
    import rdf_pkg::*;

    localparam int                 CYCLE_LIMIT = 1_000_000;
    localparam int                 TABLE_SIZE  = 16384;
    localparam int                 MAX_REPORTS = 10;
    localparam int                 END_WAIT    = 40;
    localparam int                 PHASE_ITEMS = 260;
    localparam int                 HOT_ITEMS   = 40;
    localparam logic [OUT_W-1:0]   COUNT_SAT   = 16'hFFFF;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic               is_pair;
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   s1;
        logic [POS_W-1:0]   s2;
        logic [RAND_W-1:0]  rnd;
    } read_item_t;

    typedef struct packed {
        logic             keep;
        logic             err;
        logic [OUT_W-1:0] count;
    } count_result_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_tvalid      = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata       = '0;
    logic [IN_USER_W-1:0]  s_tuser       = '0;
    logic                  m_tvalid;
    logic                  m_tready      = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    logic [OUT_W-1:0]      pair_tbl   [TABLE_SIZE];
    logic [OUT_W-1:0]      single_tbl [TABLE_SIZE];
    logic [CFG_W-1:0]      chrom_limit = CHROM_COUNT_RST;
    count_result_t         expected_counts[$];
    logic [POS_W-1:0]      key_pool [8];

    logic idle_en    = 1'b1;
    int   stall_left = 0;
    int   cycle_count;
    int   n_sent     = 0;
    int   n_checked  = 0;
    int   n_kept     = 0;
    int   n_range    = 0;
    int   n_bad      = 0;

    read_duplicate_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic count_result_t apply_request(input read_item_t it);
        count_result_t    r;
        logic [POS_W-1:0] key;
        logic [13:0]      addr;
        logic [OUT_W-1:0] cur;
        r = '0;
        if (it.req == REQ_UNUSED) begin
            return r;
        end
        key = it.s1;
        if (it.req != REQ_RESOLVE && it.is_pair && it.s2 < it.s1) begin
            key = it.s2;
        end
        if ({1'b0, it.chrom} >= chrom_limit) begin
            r.err = 1'b1;
            return r;
        end
        addr = {it.chrom, key};
        if (it.req == REQ_RESOLVE) begin
            if (pair_tbl[addr] != '0) begin
                single_tbl[addr] = '0;
                if (pair_tbl[addr] > 1) begin
                    pair_tbl[addr] = 16'((32'(it.rnd) % 32'(pair_tbl[addr])) + 1);
                end
                r.count = pair_tbl[addr];
            end else begin
                if (single_tbl[addr] > 1) begin
                    single_tbl[addr] = 16'((32'(it.rnd) % 32'(single_tbl[addr])) + 1);
                end
                r.count = single_tbl[addr];
            end
            return r;
        end
        cur = it.is_pair ? pair_tbl[addr] : single_tbl[addr];
        if (it.req == REQ_COUNT) begin
            if (cur != COUNT_SAT) begin
                cur = cur + 1'b1;
            end
        end else if (cur != '0) begin
            cur = cur - 1'b1;
            r.keep = (cur == '0);
        end
        if (it.is_pair) begin
            pair_tbl[addr] = cur;
        end else begin
            single_tbl[addr] = cur;
        end
        r.count = cur;
        return r;
    endfunction

    function automatic read_item_t make_item(input logic [REQ_W-1:0] req, input logic pair,
                                             input logic [CHROM_W-1:0] chrom,
                                             input logic [POS_W-1:0] s1,
                                             input logic [POS_W-1:0] s2,
                                             input logic [RAND_W-1:0] rnd);
        read_item_t it;
        it.req     = req;
        it.is_pair = pair;
        it.chrom   = chrom;
        it.s1      = s1;
        it.s2      = s2;
        it.rnd     = rnd;
        return it;
    endfunction

    task automatic send_item(input read_item_t it);
        int            gap;
        count_result_t predicted;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, it.rnd, it.s2, it.s1, it.chrom};
        s_tuser  <= {it.is_pair, it.req};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predicted = apply_request(it);
        expected_counts = {expected_counts, predicted};
        n_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_chrom_count(input logic [CFG_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        chrom_limit = value;
    endtask

    // Ready is held low for random bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15);
        end
        m_tready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin : check_result
        count_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result count=%0d keep=%0b error=%0b",
                             m_tdata, m_tuser[0], m_tuser[1]);
                end
            end else begin
                want = expected_counts.pop_front();
                n_checked++;
                if (want.keep) n_kept++;
                if (want.err) n_range++;
                if (m_tdata !== want.count || m_tuser[0] !== want.keep ||
                    m_tuser[1] !== want.err) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("ERROR: result %0d expected count=%0d keep=%0b error=%0b,",
                                 n_checked, want.count, want.keep, want.err);
                        $display("       got count=%0d keep=%0b error=%0b",
                                 m_tdata, m_tuser[0], m_tuser[1]);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_item(make_item(REQ_FILTER, 1'b0, 2'd0, 12'd0, 12'd0, 16'h0000));
        send_item(make_item(REQ_COUNT, 1'b0, 2'd0, 12'd0, 12'hFFF, 16'hFFFF));
        send_item(make_item(REQ_COUNT, 1'b0, 2'd0, 12'd0, 12'hFFF, 16'hFFFF));
        send_item(make_item(REQ_COUNT, 1'b1, 2'd3, 12'hFFF, 12'hFFF, 16'h0000));
        send_item(make_item(REQ_COUNT, 1'b1, 2'd3, 12'hFFF, 12'd100, 16'h0000));
        send_item(make_item(REQ_COUNT, 1'b1, 2'd0, 12'd0, 12'hFFF, 16'h0000));
        send_item(make_item(REQ_RESOLVE, 1'b1, 2'd0, 12'd0, 12'hFFF, 16'hFFFF));
        send_item(make_item(REQ_FILTER, 1'b0, 2'd0, 12'd0, 12'd0, 16'h0000));
        send_item(make_item(REQ_FILTER, 1'b1, 2'd0, 12'hFFF, 12'd0, 16'h0000));
        repeat (3) send_item(make_item(REQ_COUNT, 1'b0, 2'd1, 12'd2048, 12'd0, 16'h0000));
        send_item(make_item(REQ_RESOLVE, 1'b0, 2'd1, 12'd2048, 12'hFFF, 16'hFFFF));
        send_item(make_item(REQ_RESOLVE, 1'b1, 2'd1, 12'd2048, 12'd0, 16'h1234));
        send_item(make_item(REQ_FILTER, 1'b0, 2'd1, 12'd2048, 12'd0, 16'h0000));
        send_item(make_item(REQ_RESOLVE, 1'b0, 2'd2, 12'd100, 12'd0, 16'h0000));
        send_item(make_item(REQ_UNUSED, 1'b1, 2'd3, 12'hFFF, 12'hFFF, 16'hFFFF));
        send_item(make_item(REQ_RESOLVE, 1'b0, 2'd3, 12'd100, 12'd0, 16'h0000));
        send_item(make_item(REQ_FILTER, 1'b1, 2'd3, 12'd100, 12'hFFF, 16'h0000));
        send_item(make_item(REQ_FILTER, 1'b1, 2'd3, 12'hFFF, 12'hFFF, 16'h0000));
    endtask

    task automatic test_chrom_range();
        for (int v = 1; v <= 3; v++) begin
            set_chrom_count(CFG_W'(v));
            send_item(make_item(REQ_COUNT, 1'b0, CHROM_W'(v - 1), 12'd5, 12'd0, 16'h0000));
            send_item(make_item(REQ_COUNT, 1'b1, CHROM_W'(v), 12'd5, 12'd1, 16'h0000));
            send_item(make_item(REQ_RESOLVE, 1'b0, 2'd3, 12'd5, 12'd0, 16'hFFFF));
            send_item(make_item(REQ_FILTER, 1'b0, 2'd3, 12'd5, 12'd0, 16'h0000));
        end
        set_chrom_count(3'd4);
    endtask

    task automatic test_hot_position();
        idle_en = 1'b0;
        repeat (HOT_ITEMS) begin
            send_item(make_item(REQ_COUNT, 1'b1, 2'd2, 12'd777, 12'd3000, 16'h0000));
        end
        send_item(make_item(REQ_FILTER, 1'b1, 2'd2, 12'd777, 12'd3000, 16'h0000));
        send_item(make_item(REQ_COUNT, 1'b1, 2'd2, 12'd3000, 12'd777, 16'h0000));
        send_item(make_item(REQ_COUNT, 1'b0, 2'd2, 12'd777, 12'd0, 16'h0000));
        send_item(make_item(REQ_RESOLVE, 1'b0, 2'd2, 12'd777, 12'd0, 16'd12345));
        send_item(make_item(REQ_RESOLVE, 1'b0, 2'd2, 12'd777, 12'd0, 16'hFFFF));
        drain();
        idle_en = 1'b1;
    endtask

    task automatic test_random_mix();
        logic [CFG_W-1:0] limits [5] = '{3'd1, 3'd3, 3'd2, 3'd4, 3'd4};
        read_item_t       it;
        logic [POS_W-1:0] key;
        logic [POS_W-1:0] other;
        int               r;
        for (int ph = 0; ph < 5; ph++) begin
            set_chrom_count(limits[ph]);
            idle_en = (ph != 4);
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int k = 2; k < 8; k++) key_pool[k] = POS_W'($urandom_range(0, 4095));
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                it.req     = (r < 45) ? REQ_COUNT : (r < 80) ? REQ_FILTER :
                             (r < 97) ? REQ_RESOLVE : REQ_UNUSED;
                it.is_pair = 1'($urandom_range(0, 1));
                it.rnd     = RAND_W'($urandom_range(0, 65535));
                if ($urandom_range(0, 3) == 0) begin
                    it.chrom = CHROM_W'($urandom_range(0, 3));
                end else begin
                    it.chrom = CHROM_W'($urandom_range(0, limits[ph] - 1));
                end
                if ($urandom_range(0, 9) == 0) begin
                    it.s1 = POS_W'($urandom_range(0, 4095));
                    it.s2 = POS_W'($urandom_range(0, 4095));
                end else begin
                    key   = key_pool[$urandom_range(0, 7)];
                    other = POS_W'($urandom_range(key, 4095));
                    if (it.req == REQ_COUNT || it.req == REQ_FILTER) begin
                        if (it.is_pair && $urandom_range(0, 1) == 1) begin
                            it.s1 = other;
                            it.s2 = key;
                        end else begin
                            it.s1 = key;
                            it.s2 = other;
                        end
                    end else begin
                        it.s1 = key;
                        it.s2 = POS_W'($urandom_range(0, 4095));
                    end
                end
                send_item(it);
            end
        end
        drain();
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_counts.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            pair_tbl[i]   = '0;
            single_tbl[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_chrom_range();
        test_hot_position();
        test_random_mix();

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results in %0d cycles.",
                 n_sent, n_checked, cycle_count);
        $display("Covered %0d kept reads, %0d range errors, a heavily counted position,",
                 n_kept, n_range);
        $display("and chromosome counts 1 to 4.");
        if (n_bad == 0 && expected_counts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing.", n_bad, expected_counts.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== read_duplicate_filter.f =====
sv/rdf_pkg.sv
sv/rdf_ram.sv
sv/read_duplicate_filter.sv
dv/tb_read_duplicate_filter.sv
